>>> sv/icdf_pkg.sv
// ============================================================================
// icdf_pkg
// Shared types and fixed-point constants for the inverse normal CDF pipeline.
// ============================================================================
package icdf_pkg;

   // Control that travels down the pipeline beside the data.
   typedef struct packed {
      logic vld;   // stage holds an item
      logic low;   // p was below one half, so the result is negated
      logic zero;  // p was zero, so the result is forced
   } icdf_tag_type;

   localparam int FRAC = 28;   // fraction bits of t and the coefficients
   localparam int RW   = 64;   // square root radicand width
   localparam int TW   = RW / 2;  // root width (t)
   localparam int NW   = 34;   // numerator width
   localparam int DW   = 36;   // denominator width
   localparam int QW   = 34;   // quotient width
   localparam int ZW   = 36;   // signed z before clamping
   localparam int OW   = 32;   // quantile width

   localparam logic [31:0] LN2_Q32 = 32'hB172_17F8;
   localparam logic [31:0] C0 = 32'd675253953;
   localparam logic [31:0] C1 = 32'd215514211;
   localparam logic [31:0] C2 = 32'd2772401;
   localparam logic [31:0] D0 = 32'd384611100;
   localparam logic [31:0] D1 = 32'd50806510;
   localparam logic [31:0] D2 = 32'd351114;

endpackage

>>> sv/inverse_normal_cdf_approx.sv
// ============================================================================
// inverse_normal_cdf_approx
// Approximate standard normal quantile from a probability, fully pipelined.
// ============================================================================
// The block takes one probability beat per cycle while req_ready is high
// and returns one quantile beat per probability, in order. The pipeline
// is made of the bit-serial units laid out as stages:
// two normalization stages and 32 squaring stages for the base-two
// logarithm, one scaling stage, 32 stages of square root, three stages of
// polynomial evaluation, 34 divider stages, the fold stage at the input and
// the output register. The whole pipeline advances whenever the output
// register is empty or its beat is being taken, so a stalled result holds
// every stage in place and req_ready simply follows that condition. A zero
// probability returns the most negative quantile with invalid set.
// ============================================================================
module inverse_normal_cdf_approx #(
   parameter int PROB_BITS = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [PROB_BITS-1:0]    req_prob,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic signed [31:0]      rsp_quantile,
   output logic                    rsp_invalid
);
   import icdf_pkg::*;

   localparam int HW = $clog2(PROB_BITS + 1);
   localparam int LW = 32 + HW;
   localparam int SW = HW + 33;

   // Global advance: every stage moves when the output can take a beat.
   logic en;

   // Fold stage.
   logic [PROB_BITS:0]    q_full;
   logic [PROB_BITS-1:0]  q_ff;
   icdf_tag_type          fold_tag_in;
   icdf_tag_type          fold_tag_ff;

   // Logarithm and scaling.
   icdf_tag_type          log_tag;
   logic [LW-1:0]         nlog;
   logic [63:0]           lo_prod;
   logic [SW-1:0]         s_sum;
   logic [RW-1:0]         rad_ff;
   icdf_tag_type          scl_tag_ff;

   // Square root.
   icdf_tag_type          sq_tag;
   logic [TW-1:0]         t_root;

   // Polynomial evaluation.
   logic [63:0]           pn1, pd1, pn2, pd2, pd3;
   logic [NW-1:0]         n1_ff, n2_ff;
   logic [DW-1:0]         d1_ff, d2_ff, d3_ff;
   logic [TW-1:0]         t1_ff, t2_ff, t3_ff;
   logic [NW-1:0]         n3_ff;
   icdf_tag_type          h1_tag_ff, h2_tag_ff, h3_tag_ff;

   // Divider and output.
   icdf_tag_type          div_tag;
   logic [QW-1:0]         quo;
   logic [TW-1:0]         t_div;
   logic signed [ZW-1:0]  z_raw;
   logic signed [ZW-1:0]  z_sgn;
   logic signed [31:0]    z_out;

   logic                  out_vld_ff;
   logic signed [31:0]    quantile_ff;
   logic                  invalid_ff;

   assign en        = !out_vld_ff || rsp_ready;
   assign req_ready = en;

   // ---------------------------------------------------------------------
   // Fold p at one half: q = p below one half, otherwise 2^PROB_BITS - p.
   // ---------------------------------------------------------------------
   always_comb begin
      fold_tag_in.vld  = req_valid;
      fold_tag_in.zero = (req_prob == '0);
      fold_tag_in.low  = !req_prob[PROB_BITS-1];
      q_full = fold_tag_in.low ? {1'b0, req_prob}
                               : ({1'b1, {PROB_BITS{1'b0}}} - {1'b0, req_prob});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fold_tag_ff <= '0;
      end else if (en) begin
         fold_tag_ff <= fold_tag_in;
      end
      if (en) begin
         q_ff <= q_full[PROB_BITS-1:0];
      end
   end

   icdf_log2 #(
      .PROB_BITS (PROB_BITS)
   ) u_log2 (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .tag_in   (fold_tag_ff),
      .q_in     (q_ff),
      .tag_out  (log_tag),
      .nlog_out (nlog)
   );

   // ---------------------------------------------------------------------
   // s = 2 ln(2) L, then the radicand s << 24 in 64 bits.
   // ---------------------------------------------------------------------
   always_comb begin
      lo_prod = {32'b0, nlog[31:0]} * {32'b0, LN2_Q32};
      s_sum   = SW'({nlog[LW-1:32], 32'b0} >> 32) * SW'(LN2_Q32)
              + SW'(lo_prod[63:32]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scl_tag_ff <= '0;
      end else if (en) begin
         scl_tag_ff <= log_tag;
      end
      if (en) begin
         rad_ff <= RW'({s_sum, 25'b0});
      end
   end

   icdf_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .tag_in   (scl_tag_ff),
      .rad_in   (rad_ff),
      .tag_out  (sq_tag),
      .root_out (t_root)
   );

   // ---------------------------------------------------------------------
   // Horner evaluation of numerator and denominator, at most one product each per stage.
   // ---------------------------------------------------------------------
   always_comb begin
      pn1 = {32'b0, C2} * {32'b0, t_root};
      pd1 = {32'b0, D2} * {32'b0, t_root};
      pn2 = 64'(n1_ff) * 64'(t1_ff);
      pd2 = 64'(d1_ff) * 64'(t1_ff);
      pd3 = 64'(d2_ff) * 64'(t2_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         h1_tag_ff <= '0;
         h2_tag_ff <= '0;
         h3_tag_ff <= '0;
      end else if (en) begin
         h1_tag_ff <= sq_tag;
         h2_tag_ff <= h1_tag_ff;
         h3_tag_ff <= h2_tag_ff;
      end
      if (en) begin
         n1_ff <= NW'(pn1 >> FRAC) + NW'(C1);
         d1_ff <= DW'(pd1 >> FRAC) + DW'(D1);
         t1_ff <= t_root;
         n2_ff <= NW'(pn2 >> FRAC) + NW'(C0);
         d2_ff <= DW'(pd2 >> FRAC) + DW'(D0);
         t2_ff <= t1_ff;
         n3_ff <= n2_ff;
         d3_ff <= DW'(pd3 >> FRAC) + (DW'(1) << FRAC);
         t3_ff <= t2_ff;
      end
   end

   icdf_div #(
      .SW (TW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .tag_in   (h3_tag_ff),
      .num_in   (n3_ff),
      .den_in   (d3_ff),
      .side_in  (t3_ff),
      .tag_out  (div_tag),
      .quo_out  (quo),
      .side_out (t_div)
   );

   // ---------------------------------------------------------------------
   // z = t - quotient, negated below one half, clamped to 32 bits; forced to the minimum for p = 0.
   // ---------------------------------------------------------------------
   always_comb begin
      z_raw = $signed(ZW'(t_div)) - $signed(ZW'(quo));
      z_sgn = div_tag.low ? -z_raw : z_raw;
      if (z_sgn > $signed(ZW'(32'h7FFF_FFFF))) begin
         z_out = 32'sh7FFF_FFFF;
      end else if (z_sgn < -$signed(ZW'(33'h1_0000_0000) >>> 1)) begin
         z_out = 32'sh8000_0000;
      end else begin
         z_out = z_sgn[OW-1:0];
      end
      if (div_tag.zero) begin
         z_out = 32'sh8000_0000;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (en) begin
         out_vld_ff <= div_tag.vld;
      end
      if (en) begin
         quantile_ff <= z_out;
         invalid_ff  <= div_tag.zero;
      end
   end

   assign rsp_valid    = out_vld_ff;
   assign rsp_quantile = quantile_ff;
   assign rsp_invalid  = invalid_ff;

endmodule

>>> sv/icdf_log2.sv
// ============================================================================
// icdf_log2
// Pipelined -log2(q / 2^PROB_BITS) in Q.32: normalize, then one squaring
// round per stage to produce one fraction bit.
// ============================================================================
module icdf_log2 #(
   parameter int PROB_BITS = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 en,
   input  icdf_pkg::icdf_tag_type               tag_in,
   input  logic [PROB_BITS-1:0]                 q_in,
   output icdf_pkg::icdf_tag_type               tag_out,
   output logic [31+$clog2(PROB_BITS+1):0]      nlog_out
);
   import icdf_pkg::*;

   localparam int KW = $clog2(PROB_BITS);
   localparam int HW = $clog2(PROB_BITS + 1);
   localparam int ROUNDS = 32;

   logic [KW-1:0]          k_in;
   logic [KW-1:0]          k0_ff;
   logic [PROB_BITS-1:0]   q0_ff;
   icdf_tag_type           tag0_ff;

   logic [KW-1:0]          shamt;
   logic [PROB_BITS-1:0]   norm;
   logic [PROB_BITS+31:0]  ext_sh;
   logic [31:0]            m1_in;
   logic [HW-1:0]          hi1_in;

   logic [31:0]            m_ff   [0:ROUNDS];
   logic [31:0]            f_ff   [0:ROUNDS];
   logic [HW-1:0]          hi_ff  [0:ROUNDS];
   icdf_tag_type           tag_ff [0:ROUNDS];

   // Index of the top set bit.
   always_comb begin
      k_in = '0;
      for (int i = 0; i < PROB_BITS; i++) begin
         if (q_in[i]) begin
            k_in = KW'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag0_ff <= '0;
      end else if (en) begin
         tag0_ff <= tag_in;
      end
      if (en) begin
         k0_ff <= k_in;
         q0_ff <= q_in;
      end
   end

   // Mantissa in Q1.31 and the integer part of the result.
   always_comb begin
      shamt  = KW'(PROB_BITS - 1) - k0_ff;
      norm   = q0_ff << shamt;
      ext_sh = {norm, 32'b0} >> PROB_BITS;
      m1_in  = ext_sh[31:0];
      hi1_in = HW'(PROB_BITS) - HW'(k0_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff[0] <= '0;
      end else if (en) begin
         tag_ff[0] <= tag0_ff;
      end
      if (en) begin
         m_ff[0]  <= m1_in;
         f_ff[0]  <= '0;
         hi_ff[0] <= hi1_in;
      end
   end

   for (genvar g = 0; g < ROUNDS; g++) begin : g_round
      logic [63:0] sq;
      logic [32:0] sh;
      logic [31:0] m_in;
      logic        bit_in;

      always_comb begin
         sq     = {32'b0, m_ff[g]} * {32'b0, m_ff[g]};
         sh     = sq[63:31];
         bit_in = sh[32];
         m_in   = sh[32] ? sh[32:1] : sh[31:0];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            tag_ff[g+1] <= '0;
         end else if (en) begin
            tag_ff[g+1] <= tag_ff[g];
         end
         if (en) begin
            m_ff[g+1]  <= m_in;
            f_ff[g+1]  <= {f_ff[g][30:0], bit_in};
            hi_ff[g+1] <= hi_ff[g];
         end
      end
   end

   assign tag_out  = tag_ff[ROUNDS];
   assign nlog_out = {hi_ff[ROUNDS], 32'b0} - {{HW{1'b0}}, f_ff[ROUNDS]};

endmodule

>>> sv/icdf_sqrt.sv
// ============================================================================
// icdf_sqrt
// Pipelined integer square root, one root bit per stage.
// ============================================================================
module icdf_sqrt (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  icdf_pkg::icdf_tag_type     tag_in,
   input  logic [icdf_pkg::RW-1:0]    rad_in,
   output icdf_pkg::icdf_tag_type     tag_out,
   output logic [icdf_pkg::TW-1:0]    root_out
);
   import icdf_pkg::*;

   logic [RW-1:0]   rad_ff  [0:TW];
   logic [TW+1:0]   rem_ff  [0:TW];
   logic [TW-1:0]   root_ff [0:TW];
   icdf_tag_type    tag_ff  [0:TW];

   always_comb begin
      rad_ff[0]  = rad_in;
      rem_ff[0]  = '0;
      root_ff[0] = '0;
      tag_ff[0]  = tag_in;
   end

   for (genvar g = 0; g < TW; g++) begin : g_step
      logic [TW+3:0] acc;
      logic [TW+3:0] trial;
      logic          take;

      always_comb begin
         acc   = {rem_ff[g], rad_ff[g][RW-1 -: 2]};
         trial = {2'b0, root_ff[g], 2'b01};
         take  = (acc >= trial);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            tag_ff[g+1] <= '0;
         end else if (en) begin
            tag_ff[g+1] <= tag_ff[g];
         end
         if (en) begin
            rad_ff[g+1]  <= {rad_ff[g][RW-3:0], 2'b00};
            rem_ff[g+1]  <= take ? (TW+2)'(acc - trial) : (TW+2)'(acc);
            root_ff[g+1] <= {root_ff[g][TW-2:0], take};
         end
      end
   end

   assign tag_out  = tag_ff[TW];
   assign root_out = root_ff[TW];

endmodule

>>> sv/icdf_div.sv
// ============================================================================
// icdf_div
// Pipelined restoring divider for (num << FRAC) / den, one quotient bit per
// stage, with a side word carried alongside.
// ============================================================================
module icdf_div #(
   parameter int SW = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  icdf_pkg::icdf_tag_type     tag_in,
   input  logic [icdf_pkg::NW-1:0]    num_in,
   input  logic [icdf_pkg::DW-1:0]    den_in,
   input  logic [SW-1:0]              side_in,
   output icdf_pkg::icdf_tag_type     tag_out,
   output logic [icdf_pkg::QW-1:0]    quo_out,
   output logic [SW-1:0]              side_out
);
   import icdf_pkg::*;

   localparam int XW = NW + FRAC;

   logic [XW-1:0]   dvd;
   logic [DW-1:0]   rem_ff  [0:QW];
   logic [QW-1:0]   low_ff  [0:QW];
   logic [QW-1:0]   quo_ff  [0:QW];
   logic [DW-1:0]   den_ff  [0:QW];
   logic [SW-1:0]   side_ff [0:QW];
   icdf_tag_type    tag_ff  [0:QW];

   // The upper dividend bits are always below the denominator (which is at
   // least 1.0), so only QW quotient bits remain to be found.
   always_comb begin
      dvd        = {num_in, {FRAC{1'b0}}};
      rem_ff[0]  = DW'(dvd[XW-1:QW]);
      low_ff[0]  = dvd[QW-1:0];
      quo_ff[0]  = '0;
      den_ff[0]  = den_in;
      side_ff[0] = side_in;
      tag_ff[0]  = tag_in;
   end

   for (genvar g = 0; g < QW; g++) begin : g_step
      logic [DW:0] acc;
      logic        take;

      always_comb begin
         acc  = {rem_ff[g], low_ff[g][QW-1]};
         take = (acc >= {1'b0, den_ff[g]});
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            tag_ff[g+1] <= '0;
         end else if (en) begin
            tag_ff[g+1] <= tag_ff[g];
         end
         if (en) begin
            rem_ff[g+1]  <= take ? DW'(acc - {1'b0, den_ff[g]}) : DW'(acc);
            low_ff[g+1]  <= {low_ff[g][QW-2:0], 1'b0};
            quo_ff[g+1]  <= {quo_ff[g][QW-2:0], take};
            den_ff[g+1]  <= den_ff[g];
            side_ff[g+1] <= side_ff[g];
         end
      end
   end

   assign tag_out  = tag_ff[QW];
   assign quo_out  = quo_ff[QW];
   assign side_out = side_ff[QW];

endmodule

>>> verif/tb_inverse_normal_cdf_approx.sv
// ============================================================================
// tb_inverse_normal_cdf_approx
// Self-checking bench for the pipelined inverse normal CDF approximation.
// ============================================================================
// Probability beats go in through a bursty sender. A scoreboard computes
// the expected quantile and invalid flag for every accepted beat, in the
// block's own fixed-point steps. Each result beat is checked in order
// against the oldest expectation. The receiver stalls on a pattern of its
// own, and once it holds off long enough that the pipeline fills and the
// input stalls.
// ============================================================================
module tb_inverse_normal_cdf_approx;
   timeunit 1ns;
   timeprecision 1ps;

   // One expected result beat.
   typedef struct {
      logic signed [31:0] quantile;
      logic               invalid;
   } quantile_beat_type;

   // Computes quantiles from probabilities and keeps the ones still owed.
   class quantile_scoreboard;
      localparam longint unsigned LN2 = 64'hB172_17F8;
      localparam longint unsigned K_C0 = 675253953;
      localparam longint unsigned K_C1 = 215514211;
      localparam longint unsigned K_C2 = 2772401;
      localparam longint unsigned K_D0 = 384611100;
      localparam longint unsigned K_D1 = 50806510;
      localparam longint unsigned K_D2 = 351114;

      quantile_beat_type owed[$];
      int                errors = 0;

      static function longint unsigned int_sqrt(longint unsigned x);
         longint unsigned r = 0;
         longint unsigned b = 64'd1 << 62;
         while (b > x) b >>= 2;
         while (b != 0) begin
            if (x >= r + b) begin
               x -= r + b;
               r = (r >> 1) + b;
            end else begin
               r >>= 1;
            end
            b >>= 2;
         end
         return r;
      endfunction

      static function quantile_beat_type quantile_of(logic [31:0] prob);
         quantile_beat_type res;
         longint unsigned   q, m, f, lg, s, t, num, den, quo;
         longint            z;
         int unsigned       k;
         bit                low;
         if (prob == 0) begin
            res.quantile = 32'sh8000_0000;
            res.invalid  = 1'b1;
            return res;
         end
         low = prob < 32'h8000_0000;
         q = low ? longint'(prob) : (64'd1 << 32) - prob;
         // Base-two logarithm: normalize to Q1.31, then square 32 times.
         k = 0;
         while (k < 63 && (q >> (k + 1)) != 0) k++;
         m = (k >= 31) ? (q >> (k - 31)) : (q << (31 - k));
         f = 0;
         for (int i = 0; i < 32; i++) begin
            m = (m * m) >> 31;
            f <<= 1;
            if (m >= (64'd1 << 32)) begin
               m >>= 1;
               f |= 1;
            end
         end
         lg = ((64'd32 - k) << 32) - f;
         s = (lg >> 32) * LN2 + (((lg & 64'hFFFF_FFFF) * LN2) >> 32);
         s <<= 1;
         t = int_sqrt(s << 24);
         num = ((K_C2 * t) >> 28) + K_C1;
         num = ((num * t) >> 28) + K_C0;
         den = ((K_D2 * t) >> 28) + K_D1;
         den = ((den * t) >> 28) + K_D0;
         den = ((den * t) >> 28) + (64'd1 << 28);
         quo = (num << 28) / den;
         z = longint'(t) - longint'(quo);
         if (low) z = -z;
         if (z > 64'sd2147483647) z = 64'sd2147483647;
         if (z < -64'sd2147483648) z = -64'sd2147483648;
         res.quantile = z[31:0];
         res.invalid  = 1'b0;
         return res;
      endfunction

      function void note_prob(logic [31:0] prob);
         owed = {owed, quantile_of(prob)};
      endfunction

      function void check_result(logic signed [31:0] quantile, logic invalid);
         quantile_beat_type exp_beat;
         if (owed.size() == 0) begin
            $error("result beat with nothing expected: quantile %h", quantile);
            errors++;
            return;
         end
         exp_beat = owed.pop_front();
         if (quantile !== exp_beat.quantile) begin
            $error("quantile: expected %h, actual %h", exp_beat.quantile, quantile);
            errors++;
         end
         if (invalid !== exp_beat.invalid) begin
            $error("invalid: expected %b, actual %b", exp_beat.invalid, invalid);
            errors++;
         end
      endfunction
   endclass

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int LONG_HOLD      = 400;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [31:0]        req_prob = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [31:0] rsp_quantile;
   logic               rsp_invalid;

   quantile_scoreboard sb = new();
   bit                 hold_request = 1'b0;
   int                 idle_cycles = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   inverse_normal_cdf_approx #(.PROB_BITS(32)) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_prob    (req_prob),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_quantile(rsp_quantile),
      .rsp_invalid (rsp_invalid)
   );

   // Every accepted result beat is checked against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_result(rsp_quantile, rsp_invalid);
   end

   // The watchdog counts cycles in which neither channel moves a beat.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("inverse_normal_cdf_approx verification failed");
            $finish;
         end
      end
   end

   // The receiver switches between four stall patterns, each held for a random span.
   // When the sender asks for it, it holds off for a long stretch so that
   // the whole pipeline fills up and the input side has to stall.
   initial begin
      int mode;
      int span;
      mode = 0;
      span = 0;
      @(posedge clock);
      while (1) begin
         if (hold_request) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_request = 1'b0;
         end
         if (span == 0) begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(10, 80);
         end
         span--;
         case (mode)
            0: begin
               rsp_ready <= 1'b1;
            end
            1: begin
               rsp_ready <= $urandom_range(0, 1);
            end
            2: begin
               rsp_ready <= ($urandom_range(0, 9) == 0);
            end
            default: begin
               rsp_ready <= ($urandom_range(0, 9) != 0);
            end
         endcase
         @(posedge clock);
      end
   end

   // Offers one probability beat and waits for it to be taken. The caller
   // lowers valid only when a burst ends.
   task automatic send_prob(input logic [31:0] prob);
      req_valid <= 1'b1;
      req_prob  <= prob;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_prob(prob);
   endtask

   // A gap of zero cycles leaves valid high so the next burst follows on.
   task automatic idle_gap(input int cycles);
      if (cycles > 0) begin
         req_valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // Random probabilities: half full range, the rest deep tails on both sides
   // and values close to one half where the fold takes place.
   function automatic logic [31:0] random_prob();
      logic [31:0] v;
      v = $urandom();
      case ($urandom_range(0, 5))
         0: v = v >> $urandom_range(1, 31);
         1: v = ~(v >> $urandom_range(1, 31));
         2: v = 32'h8000_0000 + $urandom_range(0, 64) - 32;
         default: ;
      endcase
      return v;
   endfunction

   initial begin
      logic [31:0] directed[$];
      int          burst;
      bit          held;
      bit          paused;
      held   = 1'b0;
      paused = 1'b0;
      directed = '{32'h0000_0000, 32'h0000_0001, 32'h0000_0002, 32'h0000_0003,
                   32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0001, 32'hFFFF_FFFF,
                   32'hFFFF_FFFE, 32'h4000_0000, 32'hC000_0000, 32'h5555_5555,
                   32'hAAAA_AAAA, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000,
                   32'h1999_999A, 32'hE666_6666, 32'h0000_0000, 32'h0F0F_0F0F};
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed beats: extremes, the exact half, zero probability.
      foreach (directed[i]) send_prob(directed[i]);
      idle_gap(3);

      for (int n = 0; n < 1450; ) begin
         if (!held && n >= 300) begin
            // Long receiver hold while the sender keeps offering beats.
            held = 1'b1;
            hold_request = 1'b1;
            for (int j = 0; j < 200; j++) send_prob(random_prob());
            n += 200;
         end
         if (!paused && n >= 700) begin
            // Pause until every expected result has come back.
            paused = 1'b1;
            req_valid <= 1'b0;
            while (sb.owed.size() != 0) @(posedge clock);
         end
         burst = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                              : $urandom_range(1, 12);
         for (int j = 0; j < burst; j++) send_prob(random_prob());
         n += burst;
         idle_gap($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8));
      end

      req_valid <= 1'b0;
      while (sb.owed.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);
      if (sb.errors == 0) begin
         $display("inverse_normal_cdf_approx verification clean");
      end else begin
         $display("inverse_normal_cdf_approx verification failed");
      end
      $finish;
   end

endmodule

>>> inverse_normal_cdf_approx.f
sv/icdf_pkg.sv
sv/icdf_log2.sv
sv/icdf_sqrt.sv
sv/icdf_div.sv
sv/inverse_normal_cdf_approx.sv
verif/tb_inverse_normal_cdf_approx.sv
